>>> hdl/wema_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Windowed exponentially weighted average: shared package
// Transaction types, configuration register indexes and fixed widths.
// ---------------------------------------------------------------------------
package wema_pkg;

    localparam int POS_W    = 32;
    localparam int QUAL_W   = 16;
    localparam int WL_W     = 5;
    localparam int DECAY_W  = 17;
    localparam int DECAY_FRAC = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam int MAX_WINDOW_DEF       = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    localparam logic [DECAY_W-1:0] DECAY_ONE = 17'h10000;
    localparam logic [WL_W-1:0]    WL_RESET  = 5'd1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY         = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [QUAL_W-1:0]       quality;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] est_x;
        logic signed [POS_W-1:0] est_y;
        logic signed [POS_W-1:0] est_z;
        logic [QUAL_W-1:0]       quality_out;
    } out_item_t;

    typedef struct packed {
        logic wr;
        logic rd;
        logic clr;
        logic start;
    } lane_ctrl_t;

endpackage : wema_pkg
`default_nettype wire

>>> hdl/wema_wgen.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Weight generator
// Produces the weight sequence 1.0, decay, decay^2, ... by repeated
// truncating multiplication and accumulates the weight sum.
// ---------------------------------------------------------------------------
module wema_wgen
    import wema_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
    parameter int DEN_W            = WEIGHT_FRAC_BITS_DEF + 6
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        init,
    input  wire logic                        step,
    input  wire logic [DECAY_W-1:0]          decay,
    output logic      [WEIGHT_FRAC_BITS:0]   weight,
    output logic      [DEN_W-1:0]            den
);

    localparam int WW  = WEIGHT_FRAC_BITS + 1;
    localparam int MUL_W = WW + DECAY_W;

    logic [WW-1:0]    w_reg;
    logic [WW-1:0]    w_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] den_next;
    logic [MUL_W-1:0] mul_full;

    always_comb
    begin
        mul_full = MUL_W'(w_reg) * MUL_W'(decay);
        w_next   = w_reg;
        den_next = den_reg;
        if (init)
        begin
            w_next   = WW'(1) << WEIGHT_FRAC_BITS;
            den_next = '0;
        end
        else if (step)
        begin
            w_next   = mul_full[DECAY_FRAC +: WW];
            den_next = den_reg + DEN_W'(w_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg   <= '0;
            den_reg <= '0;
        end
        else
        begin
            w_reg   <= w_next;
            den_reg <= den_next;
        end
    end

    assign weight = w_reg;
    assign den    = den_reg;

endmodule : wema_wgen
`default_nettype wire

>>> hdl/wema_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Signed by unsigned divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module wema_div
    import wema_pkg::*;
#(
    parameter int ACC_W = 55,
    parameter int DEN_W = 22
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [ACC_W-1:0]  dividend,
    input  wire logic        [DEN_W-1:0]  divisor,
    output logic             [POS_W-1:0]  quotient,
    output logic                          done
);

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] mag_reg;
    logic [ACC_W-1:0] mag_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             neg_reg;
    logic             done_reg;
    logic [POS_W-1:0] quo_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        shifted  = {rem_reg, mag_reg[ACC_W-1]};
        diff     = shifted - {1'b0, dsr_reg};
        ge       = ~diff[DEN_W];
        rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        mag_next = {mag_reg[ACC_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ACC_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[ACC_W-1];
            mag_reg <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
            if (cnt_reg == CNT_W'(1))
            begin
                quo_reg <= neg_reg ? -mag_next[POS_W-1:0] : mag_next[POS_W-1:0];
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule : wema_div
`default_nettype wire

>>> hdl/wema_lane.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Axis lane
// Holds the sample ring of one axis, accumulates sample times weight over
// the window and divides the sum by the weight sum.
// ---------------------------------------------------------------------------
module wema_lane
    import wema_pkg::*;
#(
    parameter int MAX_WINDOW       = MAX_WINDOW_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
    parameter int SLOT_W           = 4,
    parameter int DEN_W            = 22,
    parameter int ACC_W            = 55
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lane_ctrl_t                  ctrl,
    input  wire logic [SLOT_W-1:0]           addr,
    input  wire logic [POS_W-1:0]            wr_data,
    input  wire logic [WEIGHT_FRAC_BITS:0]   weight,
    input  wire logic [DEN_W-1:0]            den,
    output logic      [POS_W-1:0]            est,
    output logic                             done
);

    localparam int WW     = WEIGHT_FRAC_BITS + 1;
    localparam int PROD_W = POS_W + WW + 1;

    logic [POS_W-1:0]         ring [MAX_WINDOW];
    logic [POS_W-1:0]         rd_data_reg;
    logic [WW-1:0]            w_d1_reg;
    logic                     v1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     v2_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            ring[addr] <= wr_data;
        end
        if (ctrl.rd)
        begin
            rd_data_reg <= ring[addr];
            w_d1_reg    <= weight;
        end
        prod_reg <= prod_next;
    end

    assign prod_next = $signed(rd_data_reg) * $signed({1'b0, w_d1_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            v1_reg <= ctrl.rd;
            v2_reg <= v1_reg;
            if (ctrl.clr)
            begin
                acc_reg <= '0;
            end
            else if (v2_reg)
            begin
                acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
        end
    end

    wema_div #(
        .ACC_W (ACC_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.start),
        .dividend (acc_reg),
        .divisor  (den),
        .quotient (est),
        .done     (done)
    );

endmodule : wema_lane
`default_nettype wire

>>> hdl/windowed_exp_weighted_average.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Windowed exponentially weighted average
// Stores 3-axis position samples in a ring and returns the normalised
// exponentially weighted mean of the newest samples, one lane per axis.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   in_data  (in_item_t)
//   out      output     out_valid / out_ready out_data (out_item_t)
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// After a transaction is accepted, the block walks the window over the n newest
// samples, drains the lane pipelines, runs the bit-serial dividers over the
// ACC_W-bit accumulator (55 bits by default) and then loads the result. No
// new transaction is accepted until then. in_ready is high while idle, even
// while a result waits in the output register; a second result then holds
// until that register is free. Reset empties the window, sets window length
// 1 and decay 1.0.
// ---------------------------------------------------------------------------
module windowed_exp_weighted_average
    import wema_pkg::*;
#(
    parameter int MAX_WINDOW       = MAX_WINDOW_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_item_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_item_t                   out_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (CNT_W > WL_W) ? CNT_W : WL_W;
    localparam int WW     = WEIGHT_FRAC_BITS + 1;
    localparam int DEN_W  = WW + CNT_W;
    localparam int ACC_W  = POS_W + WW + 1 + CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_START,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [WL_W-1:0]   wl_reg;
    logic [WL_W-1:0]   wl_next;
    logic [DECAY_W-1:0] decay_reg;
    logic [DECAY_W-1:0] decay_next;
    logic [SLOT_W-1:0] wslot_reg;
    logic [SLOT_W-1:0] wslot_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic [SLOT_W-1:0] raddr_reg;
    logic [SLOT_W-1:0] raddr_next;
    logic [CNT_W-1:0]  left_reg;
    logic [CNT_W-1:0]  left_next;
    logic              drain_reg;
    logic              drain_next;
    logic [QUAL_W-1:0] qual_reg;
    logic [QUAL_W-1:0] qual_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_data_reg;
    out_item_t         out_data_next;

    logic              accept;
    logic [CMP_W-1:0]  wl_ext;
    logic [CNT_W-1:0]  wl_sat;
    logic [DECAY_W-1:0] decay_sat;
    logic [SLOT_W-1:0] lane_addr;
    lane_ctrl_t        lane_ctrl;
    logic [WW-1:0]     weight;
    logic [DEN_W-1:0]  den;
    logic [POS_W-1:0]  est_x;
    logic [POS_W-1:0]  est_y;
    logic [POS_W-1:0]  est_z;
    logic              done_x;
    logic              done_y;
    logic              done_z;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign decay_sat = (decay_reg > DECAY_ONE) ? DECAY_ONE : decay_reg;

    always_comb
    begin
        wl_ext = CMP_W'(wl_reg);
        if (wl_ext == '0)
        begin
            wl_sat = CNT_W'(1);
        end
        else if (wl_ext > CMP_W'(MAX_WINDOW))
        begin
            wl_sat = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            wl_sat = CNT_W'(wl_ext);
        end
    end

    assign lane_addr       = accept ? wslot_reg : raddr_reg;
    assign lane_ctrl.wr    = accept;
    assign lane_ctrl.rd    = (state_reg == ST_WALK);
    assign lane_ctrl.clr   = accept;
    assign lane_ctrl.start = (state_reg == ST_START);

    always_comb
    begin
        state_next     = state_reg;
        wl_next        = wl_reg;
        decay_next     = decay_reg;
        wslot_next     = wslot_reg;
        fill_next      = fill_reg;
        raddr_next     = raddr_reg;
        left_next      = left_reg;
        drain_next     = drain_reg;
        qual_next      = qual_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH: wl_next    = cfg_data[WL_W-1:0];
                REG_DECAY:         decay_next = cfg_data[DECAY_W-1:0];
                default:           wl_next    = wl_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    wslot_next = (wslot_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0
                                                                         : wslot_reg + 1'b1;
                    if (fill_reg < CNT_W'(MAX_WINDOW))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    left_next  = (fill_next < wl_sat) ? fill_next : wl_sat;
                    raddr_next = wslot_reg;
                    qual_next  = in_data.quality;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                raddr_next = (raddr_reg == '0) ? SLOT_W'(MAX_WINDOW - 1) : raddr_reg - 1'b1;
                left_next  = left_reg - 1'b1;
                if (left_reg == CNT_W'(1))
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (done_x && done_y && done_z)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.est_x       = est_x;
                    out_data_next.est_y       = est_y;
                    out_data_next.est_z       = est_z;
                    out_data_next.quality_out = qual_reg;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wl_reg        <= WL_RESET;
            decay_reg     <= DECAY_ONE;
            wslot_reg     <= '0;
            fill_reg      <= '0;
            raddr_reg     <= '0;
            left_reg      <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wl_reg        <= wl_next;
            decay_reg     <= decay_next;
            wslot_reg     <= wslot_next;
            fill_reg      <= fill_next;
            raddr_reg     <= raddr_next;
            left_reg      <= left_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qual_reg     <= qual_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    wema_wgen #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
        .DEN_W            (DEN_W)
    ) u_wgen (
        .clk    (clk),
        .rst_n  (rst_n),
        .init   (accept),
        .step   (lane_ctrl.rd),
        .decay  (decay_sat),
        .weight (weight),
        .den    (den)
    );

    wema_lane #(
        .MAX_WINDOW       (MAX_WINDOW),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
        .SLOT_W           (SLOT_W),
        .DEN_W            (DEN_W),
        .ACC_W            (ACC_W)
    ) u_lane_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .addr    (lane_addr),
        .wr_data (in_data.pos_x),
        .weight  (weight),
        .den     (den),
        .est     (est_x),
        .done    (done_x)
    );

    wema_lane #(
        .MAX_WINDOW       (MAX_WINDOW),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
        .SLOT_W           (SLOT_W),
        .DEN_W            (DEN_W),
        .ACC_W            (ACC_W)
    ) u_lane_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .addr    (lane_addr),
        .wr_data (in_data.pos_y),
        .weight  (weight),
        .den     (den),
        .est     (est_y),
        .done    (done_y)
    );

    wema_lane #(
        .MAX_WINDOW       (MAX_WINDOW),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
        .SLOT_W           (SLOT_W),
        .DEN_W            (DEN_W),
        .ACC_W            (ACC_W)
    ) u_lane_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .addr    (lane_addr),
        .wr_data (in_data.pos_z),
        .weight  (weight),
        .den     (den),
        .est     (est_z),
        .done    (done_z)
    );

    // The three lanes run in lock step, so their dividers finish together.
    a_lanes_agree : assert property (@(posedge clk) disable iff (!rst_n)
        (done_x == done_y) && (done_y == done_z))
        else $error("axis lanes out of step");

    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_WINDOW))
        else $error("fill count beyond window depth");

    a_accept_walk : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_WALK) && (left_reg != '0))
        else $error("accepted transaction did not start a window walk");

    a_result_load : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && (!out_valid_reg || out_ready) |=> out_valid_reg)
        else $error("finished result not presented");

endmodule : windowed_exp_weighted_average
`default_nettype wire

>>> test/testbench.sv
// ---------------------------------------------------------------------------
// Windowed exponentially weighted average: block-level testbench
// Sends 3-axis position samples through the valid/ready input channel and
// checks every estimate against an in-bench model of the window. The model
// keeps its own sample ring and register copies. The run has a short
// directed part, covering field extremes, out-of-range register values and
// weight underflow, then random phases with fresh register settings. Both
// channels idle at random, and one phase holds the output off long enough
// to stall the input.
// ---------------------------------------------------------------------------
module testbench;
    import wema_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int TAIL_CYCLES  = 100;

    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;

    class weighted_mean_board;
        bit signed [POS_W-1:0] ring [3][MAX_WINDOW_DEF];
        int unsigned           next_slot;
        int unsigned           stored;
        bit [WL_W-1:0]         window_len;
        bit [DECAY_W-1:0]      decay_q16;
        out_item_t             expected_means[$];
        int unsigned           mismatches;

        function new();
            next_slot  = 0;
            stored     = 0;
            window_len = WL_RESET;
            decay_q16  = DECAY_ONE;
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        function void set_register(logic [CFG_IDX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] value);
            if (index == REG_WINDOW_LENGTH)
                window_len = value[WL_W-1:0];
            else if (index == REG_DECAY)
                decay_q16 = value[DECAY_W-1:0];
        endfunction

        function logic signed [POS_W-1:0] axis_mean(int axis, int unsigned count,
                                                    longint dec);
            longint      acc;
            longint      den;
            longint      w;
            longint      q;
            int unsigned slot;
            acc  = 0;
            den  = 0;
            w    = longint'(1) << WEIGHT_FRAC_BITS_DEF;
            slot = next_slot;
            for (int unsigned k = 0; k < count; k++)
            begin
                slot = (slot == 0) ? MAX_WINDOW_DEF - 1 : slot - 1;
                acc += longint'(ring[axis][slot]) * w;
                den += w;
                w = (w * dec) >> DECAY_FRAC;
            end
            q = acc / den;
            return q[POS_W-1:0];
        endfunction

        function void note_sample(in_item_t item);
            int unsigned eff_len;
            int unsigned count;
            longint      dec;
            out_item_t   mean;
            eff_len = (window_len == 0) ? 1 :
                      (window_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : window_len;
            dec = (decay_q16 > DECAY_ONE) ? longint'(DECAY_ONE) : longint'(decay_q16);
            ring[0][next_slot] = item.pos_x;
            ring[1][next_slot] = item.pos_y;
            ring[2][next_slot] = item.pos_z;
            next_slot = (next_slot + 1 >= MAX_WINDOW_DEF) ? 0 : next_slot + 1;
            if (stored < MAX_WINDOW_DEF)
                stored++;
            count = (stored < eff_len) ? stored : eff_len;
            mean.est_x       = axis_mean(0, count, dec);
            mean.est_y       = axis_mean(1, count, dec);
            mean.est_z       = axis_mean(2, count, dec);
            mean.quality_out = item.quality;
            expected_means.push_back(mean);
        endfunction

        task check_field(string name, longint got, longint want);
            if (got != want)
                report($sformatf("%s is %0d, expected %0d", name, got, want));
        endtask

        task check_estimate(out_item_t got);
            out_item_t want;
            if (expected_means.size() == 0)
            begin
                report("estimate arrived with no sample waiting for it");
                return;
            end
            want = expected_means.pop_front();
            check_field("est_x", got.est_x, want.est_x);
            check_field("est_y", got.est_y, want.est_y);
            check_field("est_z", got.est_z, want.est_z);
            check_field("quality_out", got.quality_out, want.quality_out);
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    weighted_mean_board board;
    bit                 out_idling     = 1'b1;
    int                 receiver_hold  = 0;
    int unsigned        cycle_count    = 0;

    windowed_exp_weighted_average dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic in_item_t make_sample(logic signed [POS_W-1:0] x,
                                             logic signed [POS_W-1:0] y,
                                             logic signed [POS_W-1:0] z,
                                             logic [QUAL_W-1:0] q);
        in_item_t item;
        item.pos_x   = x;
        item.pos_y   = y;
        item.pos_z   = z;
        item.quality = q;
        return item;
    endfunction

    function automatic logic signed [POS_W-1:0] random_coord();
        case ($urandom_range(0, 7))
            0:       return POS_MIN;
            1:       return POS_MAX;
            2:       return int'($urandom_range(0, 200)) - 100;
            3:       return POS_MIN + int'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WL_W-1:0] random_window();
        case ($urandom_range(0, 5))
            0:       return WL_W'(1);
            1:       return WL_W'(MAX_WINDOW_DEF);
            2:       return '0;
            3:       return WL_W'($urandom_range(MAX_WINDOW_DEF + 1, 31));
            default: return WL_W'($urandom_range(1, MAX_WINDOW_DEF));
        endcase
    endfunction

    function automatic logic [DECAY_W-1:0] random_decay();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return DECAY_ONE;
            2:       return DECAY_W'($urandom_range(65537, 131071));
            3:       return DECAY_W'($urandom_range(0, 255));
            4:       return DECAY_W'($urandom_range(60000, 65535));
            default: return DECAY_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        board.set_register(index, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [WL_W-1:0] wl, input logic [DECAY_W-1:0] dec,
                             input bit noisy_upper);
        logic [CFG_DATA_W-1:0] wdata;
        wdata = noisy_upper ? CFG_DATA_W'($urandom) : '0;
        wdata[WL_W-1:0] = wl;
        write_register(REG_WINDOW_LENGTH, wdata);
        write_register(REG_DECAY, CFG_DATA_W'(dec));
    endtask

    task automatic send_sample(input in_item_t item);
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_sample(item);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.expected_means.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int count, input bit gaps);
        for (int i = 0; i < count; i++)
        begin
            send_sample(make_sample(random_coord(), random_coord(), random_coord(),
                                    QUAL_W'($urandom)));
            if (gaps && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end
        wait_idle();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_estimate(out_data);
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (receiver_hold > 0)
            begin
                receiver_hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (stall_left == 0 && out_idling && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 11);
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else
                    out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: window of one, no decay.
        send_sample(make_sample(POS_MIN, POS_MAX, 0, 16'h0000));
        send_sample(make_sample(POS_MAX, POS_MIN, -1, 16'hFFFF));
        send_sample(make_sample(-1, 1, POS_MIN, 16'h5A5A));
        send_sample(make_sample(0, 0, POS_MAX, 16'hA5A5));
        wait_idle();

        // A zero window counts as one; zero decay keeps only the newest sample.
        configure(0, 0, 1'b0);
        send_sample(make_sample(POS_MAX, -7, 7, 16'h0001));
        send_sample(make_sample(POS_MIN, 7, -7, 16'h8000));
        wait_idle();

        // Oversized window and decay above one both saturate.
        configure(31, 17'h1FFFF, 1'b1);
        for (int i = 0; i < 10; i++)
            send_sample(make_sample(i[0] ? POS_MAX : POS_MIN, i[0] ? POS_MIN : POS_MAX,
                                    i - 5, QUAL_W'(i)));
        wait_idle();

        // The smallest non-zero decay makes the older weights underflow to zero.
        configure(WL_W'(MAX_WINDOW_DEF), 1, 1'b0);
        for (int i = 0; i < 4; i++)
            send_sample(make_sample(i[0] ? POS_MAX : POS_MIN, -i, POS_MAX - i,
                                    16'h0F0F));
        wait_idle();

        for (int p = 0; p < 14; p++)
        begin
            configure(random_window(), random_decay(), 1'b1);
            if (p == 2)
            begin
                receiver_hold = 600;
                run_phase(60, 1'b0);
            end
            else
                run_phase($urandom_range(85, 125), 1'b1);
        end

        out_idling = 1'b0;
        configure(WL_W'(MAX_WINDOW_DEF), DECAY_W'($urandom_range(32768, 65535)), 1'b1);
        run_phase(50, 1'b0);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.expected_means.size() != 0)
            board.report($sformatf("%0d estimates never arrived",
                                   board.expected_means.size()));
        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hdl/wema_pkg.sv
hdl/wema_wgen.sv
hdl/wema_div.sv
hdl/wema_lane.sv
hdl/windowed_exp_weighted_average.sv
test/testbench.sv
